>>> design/sfrp_pkg.sv
// Shared types and constants for the sync frame ring parser.
// No dependencies; every other file but sfrp_ram imports this package.
package sfrp_pkg;

   // Default sizes handed to the top-level parameters
   localparam int FIFO_DEPTH_DEF  = 256;
   localparam int PAYLOAD_MAX_DEF = 64;

   // Field widths
   localparam int CFG_W  = 7;
   localparam int LEN_W  = 11;   // count * 5 fits in 11 bits
   localparam int STAT_W = 3;

   localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 7'd64;

   // Frame bytes
   localparam logic [7:0] SYNC_HEADER = 8'h5A;
   localparam logic [7:0] TRAILER_CR  = 8'h0D;
   localparam logic [7:0] TRAILER_LF  = 8'h0A;
   localparam int         TIMES_FIVE_BIT = 7;
   localparam int         MIN_BUFFERED   = 7;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_WRITTEN   = 3'd0;
   localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_FRAME  = 3'd2;
   localparam logic [STAT_W-1:0] ST_CSUM_ERR  = 3'd3;
   localparam logic [STAT_W-1:0] ST_FRAME     = 3'd4;

   // Input item command
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [7:0]        frame_type;
      logic [7:0]        frame_count;
      logic [7:0]        payload_byte;
      logic              payload_valid;
      logic              last;
   } rsp_type;

   // Queue head offered by the front part to the back part
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

endpackage

>>> design/sfrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/sfrp_front.sv
// Front part: accepts input items into a two-entry queue.
// Depends on sfrp_pkg.
module sfrp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sfrp_pkg::req_type       req_item,
   output sfrp_pkg::queue_head_type head,
   input  logic                    pop
);
   import sfrp_pkg::*;

   req_type    slot_ff [2];
   logic       wr_idx_ff, wr_idx_in;
   logic       rd_idx_ff, rd_idx_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, take;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign take      = pop && (fill_ff != 2'd0);

   assign head.valid = (fill_ff != 2'd0);
   assign head.item  = slot_ff[rd_idx_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_idx_in = push ? ~wr_idx_ff : wr_idx_ff;
      rd_idx_in = take ? ~rd_idx_ff : rd_idx_ff;
      fill_in   = fill_ff + 2'(push) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_idx_ff] <= req_item;
      end
   end
endmodule

>>> design/sfrp_back.sv
// Back part: ring store, pointers and the frame scan sequencer.
// Depends on sfrp_pkg and sfrp_ram.
module sfrp_back #(
   parameter int FIFO_DEPTH  = sfrp_pkg::FIFO_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfrp_pkg::queue_head_type       head,
   output logic                           pop,
   input  logic [sfrp_pkg::CFG_W-1:0]     limit,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sfrp_pkg::rsp_type              rsp_item
);
   import sfrp_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_HDR, S_TYP, S_CNT, S_CR, S_LF,
      S_SUM_RD, S_SUM_WT, S_EM_RD, S_EM_LD, S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [SW-1:0]     off_ff, off_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        count_ff, count_in;
   logic [7:0]        sum_ff, sum_in;
   logic [STAT_W-1:0] code_ff, code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;
   logic [SW-1:0] rd_off;
   logic [SW-1:0] buffered;
   logic [AW-1:0] wp_next;
   logic          out_free;
   logic [LEN_W-1:0] cnt_len;
   logic [SW-1:0] len_s;

   // Offset from the read pointer, wrapped once (offsets stay below the depth)
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [SW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + off;
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[AW-1:0];
   endfunction

   sfrp_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (head.item.rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Ring occupancy and helpers
   assign buffered  = (wp_ff >= rp_ff) ? SW'(wp_ff) - SW'(rp_ff)
                                       : SW'(wp_ff) + DEPTH_S - SW'(rp_ff);
   assign wp_next   = wrap_add(wp_ff, SW'(1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ram_raddr = wrap_add(rp_ff, rd_off);
   assign len_s     = SW'(len_ff);
   // count times five, used when the type byte asks for it
   assign cnt_len   = (LEN_W'(ram_rdata) << 2) + LEN_W'(ram_rdata);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      type_in      = type_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      rd_off       = '0;
      pop          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               if (head.item.mode == MODE_CHECK) begin
                  pop      = 1'b1;
                  state_in = S_SCAN;
               end else if (out_free) begin
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_WRITTEN, frame_type: 8'd0,
                                   frame_count: 8'd0, payload_byte: 8'd0,
                                   payload_valid: 1'b0, last: 1'b1};
                  if (wp_next == rp_ff) begin
                     rsp_in.status = ST_DROPPED;
                  end else begin
                     ram_we = 1'b1;
                     wp_in  = wp_next;
                  end
               end
            end
         end
         S_SCAN: begin
            if (buffered < SW'(MIN_BUFFERED)) begin
               code_in  = ST_NO_FRAME;
               state_in = S_FIN;
            end else begin
               ram_re   = 1'b1;
               rd_off   = '0;
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            if (ram_rdata != SYNC_HEADER) begin
               rp_in    = wrap_add(rp_ff, SW'(1));
               state_in = S_SCAN;
            end else begin
               ram_re   = 1'b1;
               rd_off   = SW'(1);
               state_in = S_TYP;
            end
         end
         S_TYP: begin
            type_in  = ram_rdata;
            sum_in   = SYNC_HEADER + ram_rdata;
            ram_re   = 1'b1;
            rd_off   = SW'(2);
            state_in = S_CNT;
         end
         S_CNT: begin
            count_in = ram_rdata;
            sum_in   = sum_ff + ram_rdata;
            len_in   = type_ff[TIMES_FIVE_BIT] ? cnt_len : LEN_W'(ram_rdata);
            if (!type_ff[TIMES_FIVE_BIT]) begin
               len_in = LEN_W'(ram_rdata);
            end
            if (len_in > LEN_W'(limit)) begin
               rp_in    = wrap_add(rp_ff, SW'(1));
               state_in = S_SCAN;
            end else if (buffered <= SW'(len_in) + SW'(5)) begin
               code_in  = ST_NO_FRAME;
               state_in = S_FIN;
            end else begin
               ram_re   = 1'b1;
               rd_off   = SW'(len_in) + SW'(4);
               state_in = S_CR;
            end
         end
         S_CR: begin
            if (ram_rdata != TRAILER_CR) begin
               rp_in    = wrap_add(rp_ff, SW'(1));
               state_in = S_SCAN;
            end else begin
               ram_re   = 1'b1;
               rd_off   = len_s + SW'(5);
               state_in = S_LF;
            end
         end
         S_LF: begin
            if (ram_rdata != TRAILER_LF) begin
               rp_in    = wrap_add(rp_ff, SW'(1));
               state_in = S_SCAN;
            end else begin
               off_in   = SW'(3);
               state_in = S_SUM_RD;
            end
         end
         S_SUM_RD: begin
            ram_re   = 1'b1;
            rd_off   = off_ff;
            state_in = S_SUM_WT;
         end
         S_SUM_WT: begin
            if (off_ff == len_s + SW'(3)) begin
               // checksum byte reached
               if (ram_rdata != sum_ff) begin
                  rp_in    = wrap_add(rp_ff, len_s + SW'(6));
                  code_in  = ST_CSUM_ERR;
                  state_in = S_FIN;
               end else if (len_ff == '0) begin
                  rp_in    = wrap_add(rp_ff, SW'(6));
                  code_in  = ST_FRAME;
                  state_in = S_FIN;
               end else begin
                  off_in   = SW'(3);
                  state_in = S_EM_RD;
               end
            end else begin
               sum_in   = sum_ff + ram_rdata;
               off_in   = off_ff + SW'(1);
               state_in = S_SUM_RD;
            end
         end
         S_EM_RD: begin
            ram_re   = 1'b1;
            rd_off   = off_ff;
            state_in = S_EM_LD;
         end
         S_EM_LD: begin
            // read data holds until the result register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_FRAME, frame_type: type_ff,
                                frame_count: count_ff, payload_byte: ram_rdata,
                                payload_valid: 1'b1,
                                last: (off_ff == len_s + SW'(2))};
               if (off_ff == len_s + SW'(2)) begin
                  rp_in    = wrap_add(rp_ff, len_s + SW'(6));
                  state_in = S_IDLE;
               end else begin
                  off_in   = off_ff + SW'(1);
                  state_in = S_EM_RD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: code_ff, frame_type: 8'd0,
                                frame_count: 8'd0, payload_byte: 8'd0,
                                payload_valid: 1'b0, last: 1'b1};
               if (code_ff == ST_FRAME) begin
                  rsp_in.frame_type  = type_ff;
                  rsp_in.frame_count = count_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff   <= off_in;
      len_ff   <= len_in;
      type_ff  <= type_in;
      count_ff <= count_in;
      sum_ff   <= sum_in;
      code_ff  <= code_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

>>> design/sync_frame_ring_parser_core.sv
// Top level of the sync frame ring parser: payload-limit register,
// front queue and back sequencer. Depends on sfrp_pkg, sfrp_front, sfrp_back.
//
// Usage: req_ items carry mode and rx_byte. Mode 0 appends rx_byte to the
// receive ring and yields one rsp_ item (written or dropped when full).
// Mode 1 scans the ring from the read pointer for a 0x5A frame and yields
// one status item, or one item per payload byte of a good frame, with
// last set on the final item. csr_ writes the payload limit (reset 64); the
// user writes it only while the block is idle, which the block does not enforce.
// A check reads the ring one byte at a time through the single read port
// of the ring memory: skipped bytes, header and trailer, summed bytes and
// emitted payload bytes. A two-entry queue keeps accepting items, until it
// holds two, while the back part works or the result waits.
// Reset empties the ring pointers, the queue and the result register.
// When rsp_ready is low the result register holds, and the sequencer waits
// when it has its next result to put out; scanning goes on until then.
module sync_frame_ring_parser_core #(
   parameter int FIFO_DEPTH  = sfrp_pkg::FIFO_DEPTH_DEF,
   parameter int PAYLOAD_MAX = sfrp_pkg::PAYLOAD_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sfrp_pkg::req_type          req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sfrp_pkg::rsp_type          rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sfrp_pkg::CFG_W-1:0] csr_data
);
   import sfrp_pkg::*;

   localparam logic [CFG_W-1:0] PMAX = CFG_W'(PAYLOAD_MAX);

   logic [CFG_W-1:0] max_payload_ff, max_payload_in;
   logic [CFG_W-1:0] limit;
   queue_head_type   head;
   logic             pop;

   // Payload limit register
   assign csr_ready      = 1'b1;
   assign max_payload_in = csr_valid ? csr_data : max_payload_ff;
   assign limit          = (max_payload_ff > PMAX) ? PMAX : max_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   sfrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   sfrp_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .limit     (limit),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );
endmodule

>>> sim/tb_sync_frame_ring_parser_core.sv
// Testbench for sync_frame_ring_parser_core: directed table, then random framed traffic.
// Depends on sfrp_pkg and the core; results are checked against an in-bench ring model.
module tb_sync_frame_ring_parser_core;
   import sfrp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_data = '0;

   sync_frame_ring_parser_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Ring model state
   logic [7:0]       ring_mem [256];
   logic [7:0]       wr_ptr;
   logic [7:0]       rd_ptr;
   logic [CFG_W-1:0] limit_reg;

   rsp_type          pending_rsp [$];
   int               errors = 0;
   bit               no_idle;
   int               hold_req = 0;

   // Directed table row
   typedef struct {
      req_type it;
      bit      typed;
      rsp_type exp;
   } row_type;
   row_type          dir_rows [$];
   logic [7:0]       frame_bytes [$];

   function automatic rsp_type mk_rsp(logic [STAT_W-1:0] st, logic [7:0] ty, logic [7:0] cnt,
                                      logic [7:0] data, logic pv, logic lst);
      rsp_type r;
      r.status = st; r.frame_type = ty; r.frame_count = cnt;
      r.payload_byte = data; r.payload_valid = pv; r.last = lst;
      return r;
   endfunction

   function automatic logic [7:0] ring_at(int off);
      return ring_mem[8'(rd_ptr + off)];
   endfunction

   // Predict the results of one accepted item and update the ring model
   task automatic predict_item(req_type it);
      int lim, buffered, len;
      logic [7:0] ty, cnt, sum;
      if (it.mode == MODE_WRITE) begin
         if (8'(wr_ptr + 1) == rd_ptr) begin
            pending_rsp.push_back(mk_rsp(ST_DROPPED, 0, 0, 0, 0, 1));
         end else begin
            ring_mem[wr_ptr] = it.rx_byte;
            wr_ptr = 8'(wr_ptr + 1);
            pending_rsp.push_back(mk_rsp(ST_WRITTEN, 0, 0, 0, 0, 1));
         end
         return;
      end
      lim = (limit_reg > PAYLOAD_MAX_DEF) ? PAYLOAD_MAX_DEF : limit_reg;
      forever begin
         buffered = 8'(wr_ptr - rd_ptr);
         if (buffered < MIN_BUFFERED) break;
         if (ring_at(0) != SYNC_HEADER) begin
            rd_ptr = 8'(rd_ptr + 1);
            continue;
         end
         ty  = ring_at(1);
         cnt = ring_at(2);
         len = ty[TIMES_FIVE_BIT] ? cnt * 5 : cnt;
         if (len > lim) begin
            rd_ptr = 8'(rd_ptr + 1);
            continue;
         end
         if (buffered <= len + 5) break;
         if (ring_at(len + 4) != TRAILER_CR || ring_at(len + 5) != TRAILER_LF) begin
            rd_ptr = 8'(rd_ptr + 1);
            continue;
         end
         sum = 0;
         for (int i = 0; i < len + 3; i++) sum = sum + ring_at(i);
         if (sum != ring_at(len + 3)) begin
            pending_rsp.push_back(mk_rsp(ST_CSUM_ERR, 0, 0, 0, 0, 1));
         end else if (len == 0) begin
            pending_rsp.push_back(mk_rsp(ST_FRAME, ty, cnt, 0, 0, 1));
         end else begin
            for (int i = 0; i < len; i++)
               pending_rsp.push_back(mk_rsp(ST_FRAME, ty, cnt, ring_at(i + 3), 1,
                                            (i + 1 == len)));
         end
         rd_ptr = 8'(rd_ptr + len + 6);
         return;
      end
      pending_rsp.push_back(mk_rsp(ST_NO_FRAME, 0, 0, 0, 0, 1));
   endtask

   task automatic report(string field, int got, int want);
      $display("mismatch %s: got %0h expected %0h", field, got, want);
      errors++;
   endtask

   // Send one item with a random lead-in gap; predict at acceptance
   task automatic send_req(req_type it, bit typed = 0, rsp_type exp = '0);
      int gap, before_n;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      before_n = pending_rsp.size();
      predict_item(it);
      if (typed) begin
         while (pending_rsp.size() > before_n) void'(pending_rsp.pop_back());
         pending_rsp.push_back(exp);
      end
   endtask

   task automatic send_byte(logic [7:0] b);
      req_type it;
      it.mode = MODE_WRITE; it.rx_byte = b;
      send_req(it);
   endtask

   task automatic send_check();
      req_type it;
      it.mode = MODE_CHECK; it.rx_byte = 8'($urandom);
      send_req(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Register write, only with the block idle
   task automatic write_limit(logic [CFG_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_reg = v;
   endtask

   function automatic void add_row(logic m, logic [7:0] b, bit typed = 0, rsp_type exp = '0);
      row_type r;
      r.it.mode = m; r.it.rx_byte = b; r.typed = typed; r.exp = exp;
      dir_rows.push_back(r);
   endfunction

   // Build one frame (good or damaged) with some leading noise
   task automatic build_frame();
      int lim, len, kind;
      logic [7:0] ty, cnt, sum;
      frame_bytes.delete();
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom));
      lim = (limit_reg > PAYLOAD_MAX_DEF) ? PAYLOAD_MAX_DEF : limit_reg;
      ty = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         cnt = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom);
      end else if (ty[TIMES_FIVE_BIT]) begin
         cnt = 8'($urandom_range(0, (lim / 5 > 4) ? 4 : lim / 5));
      end else begin
         cnt = 8'($urandom_range(0, (lim > 12) ? 12 : lim));
         if ($urandom_range(0, 5) == 0) cnt = 8'(lim);
      end
      len = ty[TIMES_FIVE_BIT] ? cnt * 5 : cnt;
      if (len > 70) len = 0;
      kind = $urandom_range(0, 9);
      frame_bytes.push_back(SYNC_HEADER);
      frame_bytes.push_back(ty);
      frame_bytes.push_back(cnt);
      sum = SYNC_HEADER + ty + cnt;
      for (int i = 0; i < len; i++) begin
         frame_bytes.push_back(8'($urandom));
         sum = sum + frame_bytes[$];
      end
      frame_bytes.push_back(kind == 7 ? 8'(sum + 1) : sum);
      frame_bytes.push_back(kind == 8 ? 8'h0A : TRAILER_CR);
      frame_bytes.push_back(kind == 9 ? 8'h0D : TRAILER_LF);
   endtask

   task automatic random_phase(int n_frames);
      for (int f = 0; f < n_frames; f++) begin
         build_frame();
         foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
         send_check();
         if ($urandom_range(0, 1) != 0) send_check();
      end
   endtask

   // Stream frame bytes with no checks until n_bytes writes are sent
   task automatic fill_phase(int n_bytes);
      int sent;
      sent = 0;
      while (sent < n_bytes) begin
         build_frame();
         foreach (frame_bytes[i]) begin
            if (sent < n_bytes) begin
               send_byte(frame_bytes[i]);
               sent++;
            end
         end
      end
   endtask

   // Result side: random ready gaps, one long hold on request
   initial begin
      int gap;
      int hold_seen;
      rsp_type want;
      hold_seen = 0;
      @(negedge reset);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 8);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0) begin
            report("unexpected result, status", rsp_item.status, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.status !== want.status)
               report("status", rsp_item.status, want.status);
            if (rsp_item.frame_type !== want.frame_type)
               report("frame_type", rsp_item.frame_type, want.frame_type);
            if (rsp_item.frame_count !== want.frame_count)
               report("frame_count", rsp_item.frame_count, want.frame_count);
            if (rsp_item.payload_byte !== want.payload_byte)
               report("payload_byte", rsp_item.payload_byte, want.payload_byte);
            if (rsp_item.payload_valid !== want.payload_valid)
               report("payload_valid", rsp_item.payload_valid, want.payload_valid);
            if (rsp_item.last !== want.last)
               report("last", rsp_item.last, want.last);
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      no_idle = 0;
      wr_ptr = 0; rd_ptr = 0; limit_reg = MAX_PAYLOAD_RESET;
      foreach (ring_mem[i]) ring_mem[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty ring, a plain frame, an empty frame, a bad checksum
      add_row(MODE_CHECK, 8'hFF, 1, mk_rsp(ST_NO_FRAME, 0, 0, 0, 0, 1));
      add_row(MODE_WRITE, 8'h5A); add_row(MODE_WRITE, 8'h01);
      add_row(MODE_WRITE, 8'h02); add_row(MODE_WRITE, 8'hAA);
      add_row(MODE_WRITE, 8'hBB); add_row(MODE_WRITE, 8'hC2);
      add_row(MODE_WRITE, 8'h0D); add_row(MODE_WRITE, 8'h0A);
      add_row(MODE_CHECK, 8'h00);
      add_row(MODE_WRITE, 8'h5A); add_row(MODE_WRITE, 8'h00);
      add_row(MODE_WRITE, 8'h00); add_row(MODE_WRITE, 8'h5A);
      add_row(MODE_WRITE, 8'h0D); add_row(MODE_WRITE, 8'h0A);
      add_row(MODE_WRITE, 8'hFF);
      add_row(MODE_CHECK, 8'h00, 1, mk_rsp(ST_FRAME, 0, 0, 0, 0, 1));
      add_row(MODE_WRITE, 8'h5A); add_row(MODE_WRITE, 8'h00);
      add_row(MODE_WRITE, 8'h00); add_row(MODE_WRITE, 8'h00);
      add_row(MODE_WRITE, 8'h0D); add_row(MODE_WRITE, 8'h0A);
      add_row(MODE_WRITE, 8'hFF);
      add_row(MODE_CHECK, 8'h00, 1, mk_rsp(ST_CSUM_ERR, 0, 0, 0, 0, 1));
      foreach (dir_rows[i]) send_req(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp);

      // Random phases over several limits, extremes included
      random_phase(1);
      write_limit(7'd0);
      random_phase(2);
      write_limit(7'd7);
      no_idle = 1;
      random_phase(1);
      no_idle = 0;

      // Ring full under a long receiver stall: frames fill the ring,
      // late bytes drop, then checks work through what was kept
      write_limit(7'd127);
      hold_req++;
      fill_phase(256);
      repeat (10) send_check();

      drain();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/sfrp_pkg.sv
design/sfrp_ram.sv
design/sfrp_front.sv
design/sfrp_back.sv
design/sync_frame_ring_parser_core.sv
sim/tb_sync_frame_ring_parser_core.sv
